FILE: rtl/hdte_pkg.sv
`timescale 1ns / 1ps

package hdte_pkg;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // hex run bookkeeping
   localparam logic [5:0] DIGEST_DIGITS = 6'd32;
   localparam logic [5:0] RUN_OVER      = 6'd33;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // result kinds
   localparam logic KIND_DIGEST  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // results caused by one input word: an optional digest, then an optional summary
   typedef struct packed {
      logic        has_digest;
      logic        has_summary;
      logic [63:0] digest_high;
      logic [63:0] digest_low;
      logic [15:0] digest_count;
   } item_type;

endpackage

FILE: rtl/hdte_scanner.sv
`timescale 1ns / 1ps

module hdte_scanner
   import hdte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cfg_write,
   input  logic       cfg_mode,
   input  logic       step,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   output item_type   item
);

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_HEX   = 2'd1,
      PH_SKIP  = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        mode_ff, mode_in;
   logic [1:0]  kp_ff, kp_in;
   logic [5:0]  run_ff, run_in;
   logic [63:0] acc_hi_ff, acc_hi_in;
   logic [63:0] acc_lo_ff, acc_lo_in;
   logic [15:0] total_ff, total_in;
   logic        stopped_ff, stopped_in;

   logic        is_hex;
   logic [3:0]  digit;
   logic        line_end;
   logic        white;
   logic        found;
   logic        is_m, is_d, is_5;
   logic [63:0] shift_hi, shift_lo;

   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
         digit = 4'(text_byte - 8'h30);
      end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
         digit = 4'(text_byte - 8'h57);
      end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
         digit = 4'(text_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign line_end = (text_byte == CHAR_LF) || (text_byte == CHAR_NUL);
   assign white    = (text_byte == CHAR_TAB) || (text_byte == CHAR_LF) ||
                     (text_byte == CHAR_VT) || (text_byte == CHAR_FF) ||
                     (text_byte == CHAR_CR) || (text_byte == CHAR_SPACE);
   assign is_m     = (text_byte == 8'h6D) || (text_byte == 8'h4D);
   assign is_d     = (text_byte == 8'h64) || (text_byte == 8'h44);
   assign is_5     = (text_byte == 8'h35);
   assign shift_hi = {acc_hi_ff[59:0], acc_lo_ff[63:60]};
   assign shift_lo = {acc_lo_ff[59:0], digit};

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      kp_in      = kp_ff;
      run_in     = run_ff;
      acc_hi_in  = acc_hi_ff;
      acc_lo_in  = acc_lo_ff;
      total_in   = total_ff;
      stopped_in = stopped_ff;
      found      = 1'b0;
      item       = '0;
      if (cfg_write) begin
         mode_in  = cfg_mode;
         phase_in = PH_START;
         kp_in    = 2'd0;
         run_in   = 6'd0;
      end else if (step) begin
         if (!stopped_ff) begin
            case (phase_ff)
               PH_START: begin
                  if (!mode_ff) begin
                     // leading hex run of a plain line
                     if (is_hex) begin
                        if (run_ff < DIGEST_DIGITS) begin
                           acc_hi_in = shift_hi;
                           acc_lo_in = shift_lo;
                           run_in    = run_ff + 6'd1;
                        end else begin
                           run_in = RUN_OVER;
                        end
                     end else begin
                        found    = (run_ff == DIGEST_DIGITS) && (line_end || white);
                        run_in   = 6'd0;
                        phase_in = (text_byte == CHAR_LF) ? PH_START : PH_SKIP;
                     end
                  end else begin
                     // keyword search
                     if (text_byte == CHAR_LF) begin
                        kp_in = 2'd0;
                     end else if (text_byte == CHAR_NUL) begin
                        kp_in    = 2'd0;
                        phase_in = PH_SKIP;
                     end else if (kp_ff == 2'd2 && is_5) begin
                        kp_in    = 2'd0;
                        phase_in = PH_HEX;
                        run_in   = 6'd0;
                     end else if (kp_ff == 2'd1 && is_d) begin
                        kp_in = 2'd2;
                     end else begin
                        kp_in = is_m ? 2'd1 : 2'd0;
                     end
                  end
               end
               PH_HEX: begin
                  if (is_hex) begin
                     if (run_ff < DIGEST_DIGITS) begin
                        acc_hi_in = shift_hi;
                        acc_lo_in = shift_lo;
                        run_in    = run_ff + 6'd1;
                     end else begin
                        run_in = RUN_OVER;
                     end
                  end else begin
                     found  = (run_ff == DIGEST_DIGITS) && (line_end || white);
                     run_in = 6'd0;
                     if (text_byte == CHAR_LF) begin
                        phase_in = PH_START;
                        kp_in    = 2'd0;
                     end else if (found || text_byte == CHAR_NUL) begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               default: begin
                  if (text_byte == CHAR_LF) begin
                     phase_in = PH_START;
                     kp_in    = 2'd0;
                     run_in   = 6'd0;
                  end
               end
            endcase

            // text ends inside a run: judge it as at the end of the line
            if (end_of_text && !found && !line_end && run_in == DIGEST_DIGITS &&
                (phase_in == PH_HEX || (phase_in == PH_START && !mode_ff))) begin
               found = 1'b1;
            end

            if (found) begin
               if (total_ff != COUNT_MAX) begin
                  total_in = total_ff + 16'd1;
               end
               if (!mode_ff) begin
                  stopped_in = 1'b1;
               end
            end
         end

         item.has_digest   = found;
         item.has_summary  = end_of_text;
         item.digest_high  = acc_hi_in;
         item.digest_low   = acc_lo_in;
         item.digest_count = total_in;

         if (end_of_text) begin
            phase_in   = PH_START;
            kp_in      = 2'd0;
            run_in     = 6'd0;
            acc_hi_in  = 64'd0;
            acc_lo_in  = 64'd0;
            total_in   = 16'd0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         phase_ff   <= PH_START;
         kp_ff      <= 2'd0;
         run_ff     <= 6'd0;
         acc_hi_ff  <= 64'd0;
         acc_lo_ff  <= 64'd0;
         total_ff   <= 16'd0;
         stopped_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         kp_ff      <= kp_in;
         run_ff     <= run_in;
         acc_hi_ff  <= acc_hi_in;
         acc_lo_ff  <= acc_lo_in;
         total_ff   <= total_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

FILE: rtl/hex_digest_token_extractor.sv
`timescale 1ns / 1ps

// hex digest token extractor
// req channel: one text byte per word plus an end_of_text flag; a byte of 10
//    ends a line. csr channel: one word writes annotated_mode (0 plain digest
//    list, 1 search each line after an "md5" keyword); always ready, and a
//    write restarts the current line. write it only while the block is idle.
// rsp channel: digest words (kind 0, 128-bit packed value and running count)
//    and an end of text summary word (kind 1, final count), last marks the
//    final word caused by one byte.
// visibility: a result is on rsp in the cycle after its byte is accepted when
//    the queue ahead of it is empty, later when older words are still waiting.
// throughput: one byte per cycle while rsp_ready holds and each byte gives
//    at most one word; a byte giving a digest and a summary sends two words.
//    the rate is set by the single rsp port draining a two-entry result queue.
// stall: the queue holds two bytes' worth of results; req_ready drops only
//    when both entries are full, so a stalled receiver backs up into req.
// reset: synchronous, clears the scan state, the mode register and the queue.
module hex_digest_token_extractor
   import hdte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // text bytes in
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   // results out
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [63:0] rsp_digest_high,
   output logic [63:0] rsp_digest_low,
   output logic [15:0] rsp_digest_count,
   output logic        rsp_last,
   // mode register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_annotated_mode
);

   logic     req_fire;
   logic     rsp_fire;
   logic     csr_fire;
   item_type item;

   // two-entry result queue, one entry per byte that gives any result
   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       digest_done_ff, digest_done_in;   // head digest already sent
   item_type   head;
   logic       show_digest;
   logic       push;
   logic       pop;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = (count_ff != 2'd2);
   assign req_fire  = req_valid & req_ready;

   hdte_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .cfg_write   (csr_fire),
      .cfg_mode    (csr_annotated_mode),
      .step        (req_fire),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .item        (item)
   );

   assign push = req_fire && (item.has_digest || item.has_summary);

   // head entry: digest first, then the summary if the byte ended the text
   assign head        = q_ff[rd_ptr_ff];
   assign show_digest = head.has_digest && !digest_done_ff;
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_fire    = rsp_valid & rsp_ready;
   assign pop         = rsp_fire && (!show_digest || !head.has_summary);

   assign rsp_result_kind  = show_digest ? KIND_DIGEST : KIND_SUMMARY;
   assign rsp_digest_high  = show_digest ? head.digest_high : 64'd0;
   assign rsp_digest_low   = show_digest ? head.digest_low : 64'd0;
   assign rsp_digest_count = head.digest_count;
   assign rsp_last         = !show_digest || !head.has_summary;

   always_comb begin
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      count_in       = count_ff;
      digest_done_in = digest_done_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in      = ~rd_ptr_ff;
         digest_done_in = 1'b0;
      end else if (rsp_fire) begin
         digest_done_in = 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         count_ff       <= 2'd0;
         digest_done_ff <= 1'b0;
      end else begin
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
         digest_done_ff <= digest_done_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   // queue never holds more than its two entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue count out of range");

   // a byte with results is visible on rsp in the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("pushed result not visible");

   // a digest that is not last is followed directly by its summary
   a_digest_then_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_result_kind == KIND_DIGEST && !rsp_last
      |=> rsp_valid && rsp_result_kind == KIND_SUMMARY)
      else $error("summary lost after digest");

   // a summary word is always last and carries no digest
   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SUMMARY
      |-> rsp_last && rsp_digest_high == 64'd0 && rsp_digest_low == 64'd0)
      else $error("malformed summary word");

endmodule
